// ----- rtl/core/urldec_pkg.sv -----
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the decoder.
package urldec_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PCT    = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UP_F   = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LO_F   = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CASE_GAP    = 8'h20;  // 'a' - 'A'
  localparam logic [CHAR_W-1:0] ALPHA_BIAS  = 8'h37;  // 'A' - 10

  // One queue entry: up to three results, emitted in field order
  // (literal percent, held digit, body byte).
  typedef struct packed {
    logic              pct;
    logic              held_v;
    logic [CHAR_W-1:0] held;
    logic              body_v;
    logic [CHAR_W-1:0] body;
    logic              fin;
  } cmd_t;

  function automatic logic is_hex(logic [CHAR_W-1:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
           ((c >= CHAR_UP_A) && (c <= CHAR_UP_F)) ||
           ((c >= CHAR_LO_A) && (c <= CHAR_LO_F));
  endfunction

  function automatic logic [3:0] hex_val(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] v;
    u = (c >= CHAR_LO_A) ? (c - CASE_GAP) : c;
    v = (u >= CHAR_UP_A) ? (u - ALPHA_BIAS) : (u - CHAR_ZERO);
    return v[3:0];
  endfunction

endpackage

// ----- rtl/core/urldec_front.sv -----
// Front end: accepts encoded bytes, tracks the escape phase and builds queue entries.
// Depends on urldec_pkg.
module urldec_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [urldec_pkg::CHAR_W-1:0]       in_char_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output urldec_pkg::cmd_t                    q_cmd_o
);
  import urldec_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CHAR_W-1:0] held_q, held_d;
  logic              accept;
  logic              idle_path;
  cmd_t              cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd       = '0;
    phase_d   = phase_q;
    held_d    = held_q;
    idle_path = 1'b0;
    case (phase_q)
      PH_PCT: begin
        if (is_hex(in_char_i)) begin
          held_d  = in_char_i;
          phase_d = PH_DIGIT;
        end else begin
          cmd.pct   = 1'b1;
          idle_path = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(in_char_i)) begin
          cmd.body_v = 1'b1;
          cmd.body   = {hex_val(held_q), hex_val(in_char_i)};
          phase_d    = PH_IDLE;
        end else begin
          cmd.pct    = 1'b1;
          cmd.held_v = 1'b1;
          cmd.held   = held_q;
          idle_path  = 1'b1;
        end
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase
    if (idle_path) begin
      phase_d = PH_IDLE;
      if (in_char_i == CHAR_NUL) begin
        cmd.body_v = 1'b1;
        cmd.body   = CHAR_NUL;
        cmd.fin    = 1'b1;
      end else if (in_char_i == CHAR_PCT) begin
        phase_d = PH_PCT;
      end else if (in_char_i == CHAR_PLUS) begin
        cmd.body_v = 1'b1;
        cmd.body   = CHAR_SPACE;
      end else begin
        cmd.body_v = 1'b1;
        cmd.body   = in_char_i;
      end
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept && (cmd.pct || cmd.held_v || cmd.body_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= CHAR_NUL;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_held_is_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIGIT |-> is_hex(held_q))
    else $error("held digit is not a hex character");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> accept && !q_full_i)
    else $error("queue push without an accepted byte");

  a_pct_enters_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_IDLE && in_char_i == CHAR_PCT |=> phase_q == PH_PCT)
    else $error("percent sign did not open an escape");
`endif

endmodule

// ----- rtl/core/urldec_fifo.sv -----
// Short queue of decoded entries between front end and back end.
// Depends on urldec_pkg for the entry type.
module urldec_fifo #(
  parameter int unsigned Depth = urldec_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  urldec_pkg::cmd_t push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output urldec_pkg::cmd_t head_o
);
  import urldec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : (p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/core/urldec_back.sv -----
// Back end: splits queue entries into single output bytes behind an output register.
// Depends on urldec_pkg.
module urldec_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  urldec_pkg::cmd_t              q_head_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [urldec_pkg::CHAR_W-1:0] out_char_o,
  output logic                          out_final_o
);
  import urldec_pkg::*;

  cmd_t              cur_q, cur_d;
  cmd_t              src;
  logic              cur_pend;
  logic              src_valid;
  logic              can_load;
  logic              load;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_fin;
  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              final_q;

  assign cur_pend  = cur_q.pct || cur_q.held_v || cur_q.body_v;
  assign src       = cur_pend ? cur_q : q_head_i;
  assign src_valid = cur_pend || !q_empty_i;
  assign can_load  = !valid_q || out_ready_i;
  assign load      = can_load && src_valid;
  assign q_pop_o   = load && !cur_pend;

  // Take the first pending part, keep the rest for following cycles.
  always_comb begin
    cur_d     = src;
    emit_fin  = 1'b0;
    if (src.pct) begin
      emit_char = CHAR_PCT;
      cur_d.pct = 1'b0;
    end else if (src.held_v) begin
      emit_char    = src.held;
      cur_d.held_v = 1'b0;
    end else begin
      emit_char    = src.body;
      emit_fin     = src.fin;
      cur_d.body_v = 1'b0;
      cur_d.fin    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      valid_q <= 1'b0;
      char_q  <= CHAR_NUL;
      final_q <= 1'b0;
    end else begin
      if (load) begin
        cur_q   <= cur_d;
        valid_q <= 1'b1;
        char_q  <= emit_char;
        final_q <= emit_fin;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_final_o = final_q;

`ifndef ASSERT_OFF
  a_final_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && final_q |-> char_q == CHAR_NUL)
    else $error("terminator byte is not zero");

  a_pop_only_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !cur_pend && can_load)
    else $error("queue popped while an entry is still being split");

  a_fin_with_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q.fin |-> cur_q.body_v)
    else $error("terminator flag pending without its byte");
`endif

endmodule

// ----- rtl/core/url_percent_decoder.sv -----
// URL percent decoder top level: front end, entry queue and back end.
// A byte accepted by the front end is written into the queue, then into the back end's output register.
// Throughput: one input byte per cycle while the queue has room; one result per cycle out while the receiver is ready.
// A byte giving k results (at most 3) is split by the back end one result at a time; the queue absorbs it.
// Reset (rst_ni low, asynchronous) returns the escape phase to idle and empties the queue.
// Depends on urldec_pkg, urldec_front, urldec_fifo and urldec_back.
module url_percent_decoder #(
  parameter int unsigned QueueDepth = urldec_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Encoded stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [urldec_pkg::CHAR_W-1:0] s_axis_tdata,   // [7:0] in_char
  // Decoded stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [urldec_pkg::CHAR_W-1:0] m_axis_tdata,   // [7:0] out_char
  output logic                          m_axis_tlast    // out_final
);
  import urldec_pkg::*;

  // Entry handed from the front end to the queue, and the queue head to the back end
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // Classify each byte against the escape phase; hold a lone hex digit until
  // the next byte decides whether the escape completes.
  urldec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // Decouple the two sides so a multi-byte flush does not stall the input.
  urldec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  // Emit one byte per transaction; the terminator carries tlast.
  urldec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_final_o (m_axis_tlast)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for url_percent_decoder: a directed table, then random strings.
// Predicts every decoded byte in the bench itself; depends on urldec_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import urldec_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned CALM_FROM    = 260;  // transactions without idling on either side
  localparam int unsigned CALM_TO      = 360;
  localparam int unsigned SETTLE       = 8;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PCT,
    ESC_DIGIT
  } esc_phase_e;

  // One encoded byte; pinned rows carry a decoded byte typed in by hand.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              pinned;
    logic [CHAR_W-1:0] pin_ch;
    logic              pin_fin;
  } enc_item_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } dec_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [CHAR_W-1:0] s_axis_tdata;   // [7:0] in_char
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CHAR_W-1:0] m_axis_tdata;   // [7:0] out_char
  logic              m_axis_tlast;   // out_final

  enc_item_t  encoded_q[$];
  dec_item_t  decoded_q[$];
  esc_phase_e esc_phase = ESC_IDLE;
  logic [CHAR_W-1:0] held_digit = '0;

  int unsigned n_sent    = 0;
  int unsigned n_recv    = 0;
  int unsigned n_strings = 0;
  int unsigned n_errors  = 0;
  int unsigned n_cycles  = 0;
  logic        calm;

  assign calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

  url_percent_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic hex_digit(logic [CHAR_W-1:0] c);
    return (c inside {[CHAR_ZERO:CHAR_NINE], [CHAR_UP_A:CHAR_UP_F], [CHAR_LO_A:CHAR_LO_F]});
  endfunction

  function automatic logic [3:0] nibble_of(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if (c <= CHAR_NINE) v = c - CHAR_ZERO;
    else if (c <= CHAR_UP_F) v = c - CHAR_UP_A + 8'd10;
    else v = c - CHAR_LO_A + 8'd10;
    return v[3:0];
  endfunction

  task automatic expect_byte(input logic [CHAR_W-1:0] c, input logic fin);
    dec_item_t d;
    d.ch  = c;
    d.fin = fin;
    decoded_q.push_back(d);
  endtask

  // Handle a byte as seen from the idle phase.
  task automatic decode_plain(input logic [CHAR_W-1:0] c);
    esc_phase = ESC_IDLE;
    if (c == CHAR_NUL) expect_byte(CHAR_NUL, 1'b1);
    else if (c == CHAR_PCT) esc_phase = ESC_PCT;
    else if (c == CHAR_PLUS) expect_byte(CHAR_SPACE, 1'b0);
    else expect_byte(c, 1'b0);
  endtask

  task automatic decode_byte(input logic [CHAR_W-1:0] c);
    case (esc_phase)
      ESC_PCT: begin
        if (hex_digit(c)) begin
          held_digit = c;
          esc_phase  = ESC_DIGIT;
        end else begin
          // Lone percent: emit it literally, then take the byte afresh
          expect_byte(CHAR_PCT, 1'b0);
          decode_plain(c);
        end
      end
      ESC_DIGIT: begin
        if (hex_digit(c)) begin
          expect_byte({nibble_of(held_digit), nibble_of(c)}, 1'b0);
          esc_phase = ESC_IDLE;
        end else begin
          // Half an escape: flush percent and the held digit unchanged
          expect_byte(CHAR_PCT, 1'b0);
          expect_byte(held_digit, 1'b0);
          decode_plain(c);
        end
      end
      default: decode_plain(c);
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_item(input logic [CHAR_W-1:0] c, input logic pinned = 1'b0,
                          input logic [CHAR_W-1:0] pin_ch = '0, input logic pin_fin = 1'b0);
    enc_item_t e;
    e.ch      = c;
    e.pinned  = pinned;
    e.pin_ch  = pin_ch;
    e.pin_fin = pin_fin;
    encoded_q.push_back(e);
  endtask

  function automatic logic [CHAR_W-1:0] rand_hex();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) return CHAR_ZERO + v;
    return ($urandom_range(1) ? CHAR_UP_A : CHAR_LO_A) + v - 8'd10;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_non_hex();
    logic [CHAR_W-1:0] c;
    c = 8'($urandom_range(255));
    while (hex_digit(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic build_stimulus();
    int unsigned kind;
    // Directed table: plain bytes, the extremes, plus, escapes and every broken escape
    add_item(8'h61, 1'b1, 8'h61, 1'b0);            // 'a' straight after reset
    add_item(8'hFF, 1'b1, 8'hFF, 1'b0);            // top byte passes through
    add_item(CHAR_NUL, 1'b1, CHAR_NUL, 1'b1);      // string terminator
    add_item(CHAR_PLUS, 1'b1, CHAR_SPACE, 1'b0);
    add_item(CHAR_PCT);
    add_item(8'h34);
    add_item(8'h31, 1'b1, 8'h41, 1'b0);            // %41 -> 'A'
    add_item(CHAR_PCT);
    add_item(8'h66);
    add_item(8'h46, 1'b1, 8'hFF, 1'b0);            // %fF, mixed case
    add_item(CHAR_PCT);
    add_item(8'h47);                               // percent, then no hex digit
    add_item(CHAR_PCT);
    add_item(8'h41);
    add_item(8'h7A);                               // percent with one digit only
    add_item(CHAR_PCT);
    add_item(CHAR_PCT);                            // percent restarts the escape
    add_item(8'h32);
    add_item(8'h30);
    add_item(CHAR_PCT);
    add_item(CHAR_PLUS);
    add_item(CHAR_PCT);
    add_item(8'h33);
    add_item(CHAR_NUL);                            // terminator inside an escape
    add_item(CHAR_PCT);
    add_item(CHAR_NUL);

    // Random part: mostly well-formed strings with random content, some noise
    while (encoded_q.size() < 26 + RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        add_item(8'($urandom_range(1, 255)));
      end else if (kind < 45) begin
        add_item(CHAR_PLUS);
      end else if (kind < 72) begin
        add_item(CHAR_PCT);
        add_item(rand_hex());
        add_item(rand_hex());
      end else if (kind < 84) begin
        add_item(CHAR_PCT);
        if ($urandom_range(1)) add_item(rand_hex());
        add_item(rand_non_hex());
      end else if (kind < 92) begin
        add_item(CHAR_NUL);
      end else begin
        add_item(8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH at result %0d: %s got 0x%02h, expected 0x%02h", n_recv, what, got, want);
    n_errors++;
  endtask

  // Sample both transaction groups at the rising edge.
  always @(posedge clk_i) begin
    dec_item_t want;
    int unsigned depth;
    if (rst_ni) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding", n_cycles,
                 decoded_q.size());
        $display("Verification failed");
        $finish;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        depth = decoded_q.size();
        decode_byte(s_axis_tdata);
        // Pinned rows: replace the predicted byte with the hand-typed one
        if (encoded_q[n_sent].pinned) begin
          while (decoded_q.size() > depth) void'(decoded_q.pop_back());
          expect_byte(encoded_q[n_sent].pin_ch, encoded_q[n_sent].pin_fin);
        end
        n_sent++;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          flag_mismatch("unexpected byte, nothing outstanding; out_char", m_axis_tdata, 0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.ch) flag_mismatch("out_char", m_axis_tdata, want.ch);
          if (m_axis_tlast !== want.fin) flag_mismatch("out_final", m_axis_tlast, want.fin);
        end
        if (m_axis_tlast === 1'b1) n_strings++;
        n_recv++;
      end
    end
  end

  // Receiver: stall at random except in the calm stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Sender, reset and end of run.
  initial begin
    int unsigned k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    build_stimulus();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (k = 0; k < encoded_q.size(); k++) begin
      // Hold off at random, with junk on the data lines
      while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'($urandom_range(255));
        @(negedge clk_i);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = encoded_q[k].ch;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;

    // Drain, then wait out SETTLE to show any stray byte
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d encoded bytes (directed escapes, broken escapes, random strings).",
             n_sent);
    $display("Checked %0d decoded bytes across %0d terminated strings in %0d cycles.",
             n_recv, n_strings, n_cycles);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
